// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// Depends on nothing; the user module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/efr_pkg.sv =====
// Shared types, codes and constants of the escaped frame receiver.
// No dependencies; used by efr_step and escaped_frame_receiver_unit.
package efr_pkg;

  localparam int BufDepth = 2048;
  localparam int CountW   = $clog2(BufDepth + 1);

  // Field widths of the transactions
  localparam int EvW    = 3;
  localparam int IdxW   = 11;
  localparam int LenW   = 12;
  localparam int DelayW = 16;
  localparam int TmoW   = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Phase codes
  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhFrame = 2'd1;
  localparam logic [1:0] PhCmd   = 2'd2;

  // Result event codes
  localparam logic [EvW-1:0] EvStored   = 3'd0;
  localparam logic [EvW-1:0] EvDone     = 3'd1;
  localparam logic [EvW-1:0] EvReboot   = 3'd2;
  localparam logic [EvW-1:0] EvAbort    = 3'd3;
  localparam logic [EvW-1:0] EvOverflow = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStartByte  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEndByte    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEscapeByte = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgInitTmo    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgByteCredit = 3'd4;

  // Reboot command bytes and positions
  localparam logic [7:0] CmdSync  = 8'h55;
  localparam logic [7:0] CmdByte1 = 8'hAA;
  localparam logic [7:0] CmdByte2 = 8'h01;
  localparam logic [7:0] CmdByte3 = 8'hE7;
  localparam logic [7:0] CmdByte5 = 8'h02;
  localparam logic [3:0] CmdPosDelayLo = 4'd7;
  localparam logic [3:0] CmdPosDelayHi = 4'd8;
  localparam logic [3:0] CmdPosLast    = 4'd10;

  // Reset values
  localparam logic [7:0]        RstStartByte  = 8'hE1;
  localparam logic [7:0]        RstEndByte    = 8'hE2;
  localparam logic [7:0]        RstEscapeByte = 8'hE0;
  localparam logic [TmoW-1:0]   RstInitTmo    = 16'd50;
  localparam logic [7:0]        RstByteCredit = 8'd2;
  localparam logic [DelayW-1:0] RstDelay      = 16'd5000;

  typedef struct packed {
    logic [7:0]      start_byte;
    logic [7:0]      end_byte;
    logic [7:0]      escape_byte;
    logic [TmoW-1:0] initial_timeout;
    logic [7:0]      byte_credit;
  } efr_cfg_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic              escape_pending;
    logic [CountW-1:0] stored_count;
    logic [3:0]        command_count;
    logic [TmoW-1:0]   timeout_left;
    logic [7:0]        delay_low;
    logic [DelayW-1:0] delay_value;
  } efr_state_t;

  typedef struct packed {
    logic              valid;
    logic [EvW-1:0]    event_res;
    logic [7:0]        data_byte;
    logic [IdxW-1:0]   byte_index;
    logic [LenW-1:0]   frame_length;
    logic [DelayW-1:0] reboot_delay;
  } efr_result_t;

endpackage

// ===== hdl/efr_step.sv =====
// Next-state and result logic for one byte or tick of the frame receiver.
// Depends on efr_pkg; purely combinational.
module efr_step (
  input  efr_pkg::efr_cfg_t    cfg_i,
  input  efr_pkg::efr_state_t  state_i,
  input  logic                 mode_i,
  input  logic [7:0]           rx_byte_i,
  output efr_pkg::efr_state_t  state_o,
  output efr_pkg::efr_result_t res_o
);

  logic                        busy;
  logic [efr_pkg::TmoW-1:0]    tmo_dec;
  logic [efr_pkg::TmoW:0]      tmo_sum;
  logic [efr_pkg::TmoW-1:0]    tmo_sat;
  logic                        cmd_bad;
  logic [7:0]                  dec_byte;
  logic [efr_pkg::CountW-1:0]  cnt_inc;

  assign busy    = (state_i.phase == efr_pkg::PhFrame) || (state_i.phase == efr_pkg::PhCmd);
  assign tmo_dec = (state_i.timeout_left != '0) ? state_i.timeout_left - 1'b1 : '0;
  assign tmo_sum = {1'b0, state_i.timeout_left}
                 + {{(efr_pkg::TmoW - 8 + 1){1'b0}}, cfg_i.byte_credit};
  assign tmo_sat = tmo_sum[efr_pkg::TmoW] ? '1 : tmo_sum[efr_pkg::TmoW-1:0];
  assign dec_byte = state_i.escape_pending ? (cfg_i.escape_byte + rx_byte_i) : rx_byte_i;
  assign cnt_inc  = state_i.stored_count + 1'b1;

  always_comb begin
    cmd_bad = 1'b0;
    unique case (state_i.command_count)
      4'd1:    cmd_bad = (rx_byte_i != efr_pkg::CmdByte1);
      4'd2:    cmd_bad = (rx_byte_i != efr_pkg::CmdByte2);
      4'd3:    cmd_bad = (rx_byte_i != efr_pkg::CmdByte3);
      4'd5:    cmd_bad = (rx_byte_i != efr_pkg::CmdByte5);
      default: cmd_bad = 1'b0;
    endcase
  end

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (mode_i) begin
      // tick: count down, abort on expiry
      if (busy) begin
        state_o.timeout_left = tmo_dec;
        if (tmo_dec == '0) begin
          state_o.phase          = efr_pkg::PhIdle;
          state_o.command_count  = '0;
          state_o.escape_pending = 1'b0;
          res_o.valid            = 1'b1;
          res_o.event_res        = efr_pkg::EvAbort;
        end
      end
    end else if (!busy) begin
      state_o.phase = efr_pkg::PhIdle;
      if (rx_byte_i == cfg_i.start_byte || rx_byte_i == efr_pkg::CmdSync) begin
        state_o.escape_pending = 1'b0;
        state_o.timeout_left   = cfg_i.initial_timeout;
        if (rx_byte_i == cfg_i.start_byte) begin
          state_o.stored_count = efr_pkg::CountW'(1);
        end else begin
          state_o.command_count = 4'd1;
        end
        res_o.valid = 1'b1;
        if (cfg_i.initial_timeout == '0) begin
          state_o.command_count = '0;
          res_o.event_res       = efr_pkg::EvAbort;
        end else if (rx_byte_i == cfg_i.start_byte) begin
          state_o.phase   = efr_pkg::PhFrame;
          res_o.event_res = efr_pkg::EvStored;
          res_o.data_byte = rx_byte_i;
        end else begin
          state_o.phase = efr_pkg::PhCmd;
          res_o.valid   = 1'b0;
        end
      end
    end else if (state_i.phase == efr_pkg::PhFrame) begin
      res_o.valid = 1'b1;
      if (state_i.stored_count >= efr_pkg::CountW'(efr_pkg::BufDepth)) begin
        res_o.event_res = efr_pkg::EvOverflow;
      end else begin
        state_o.timeout_left = tmo_sat;
        if (!state_i.escape_pending && rx_byte_i == cfg_i.escape_byte) begin
          state_o.escape_pending = 1'b1;
          res_o.valid            = 1'b0;
          if (tmo_sat == '0) begin
            state_o.phase          = efr_pkg::PhIdle;
            state_o.command_count  = '0;
            state_o.escape_pending = 1'b0;
            res_o.valid            = 1'b1;
            res_o.event_res        = efr_pkg::EvAbort;
          end
        end else begin
          state_o.stored_count = cnt_inc;
          if (!state_i.escape_pending && rx_byte_i == cfg_i.end_byte) begin
            state_o.phase      = efr_pkg::PhIdle;
            res_o.event_res    = efr_pkg::EvDone;
            res_o.data_byte    = dec_byte;
            res_o.byte_index   = efr_pkg::IdxW'(state_i.stored_count);
            res_o.frame_length = efr_pkg::LenW'(cnt_inc);
          end else begin
            state_o.escape_pending = 1'b0;
            if (tmo_sat == '0) begin
              state_o.phase         = efr_pkg::PhIdle;
              state_o.command_count = '0;
              res_o.event_res       = efr_pkg::EvAbort;
            end else begin
              res_o.event_res  = efr_pkg::EvStored;
              res_o.data_byte  = dec_byte;
              res_o.byte_index = efr_pkg::IdxW'(state_i.stored_count);
            end
          end
        end
      end
    end else begin
      // reboot command body
      if (cmd_bad) begin
        state_o.timeout_left   = '0;
        state_o.phase          = efr_pkg::PhIdle;
        state_o.command_count  = '0;
        state_o.escape_pending = 1'b0;
        res_o.valid            = 1'b1;
        res_o.event_res        = efr_pkg::EvAbort;
      end else begin
        if (state_i.command_count == efr_pkg::CmdPosDelayLo) begin
          state_o.delay_low = rx_byte_i;
        end
        if (state_i.command_count == efr_pkg::CmdPosDelayHi) begin
          state_o.delay_value = {rx_byte_i, state_i.delay_low};
        end
        state_o.command_count = state_i.command_count + 1'b1;
        if (state_i.command_count >= efr_pkg::CmdPosLast) begin
          state_o.command_count = '0;
          state_o.phase         = efr_pkg::PhIdle;
          res_o.valid           = 1'b1;
          res_o.event_res       = efr_pkg::EvReboot;
          res_o.reboot_delay    = state_o.delay_value;
        end else if (state_i.timeout_left == '0) begin
          state_o.phase          = efr_pkg::PhIdle;
          state_o.command_count  = '0;
          state_o.escape_pending = 1'b0;
          res_o.valid            = 1'b1;
          res_o.event_res        = efr_pkg::EvAbort;
        end
      end
    end
  end

endmodule

// ===== hdl/escaped_frame_receiver_unit.sv =====
// Top level of the escaped frame receiver: channel registers, state, config.
// Depends on efr_pkg, efr_step and assert_macros.svh.
//
// Channel   Dir  Handshake             Payload
// in        in   in_valid_i/in_ready_o   mode_i, rx_byte_i
// out       out  out_valid_o/out_ready_i event_res_o, data_byte_o, byte_index_o,
//                                        frame_length_o, reboot_delay_o
// cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each transaction passes through the input register and then the result
// register; one item is taken per cycle while the output is not stalled.
// The combinational step logic reads and updates the state in the same cycle.
// Reset clears both valid flags, clears state but for the default reboot delay, and loads the register defaults.
// A stalled output holds the input register; items without a result still
// wait for a free output slot. Config writes are always taken.
`include "assert_macros.svh"

module escaped_frame_receiver_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [7:0]                      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [efr_pkg::EvW-1:0]         event_res_o,
  output logic [7:0]                      data_byte_o,
  output logic [efr_pkg::IdxW-1:0]        byte_index_o,
  output logic [efr_pkg::LenW-1:0]        frame_length_o,
  output logic [efr_pkg::DelayW-1:0]      reboot_delay_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [efr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [efr_pkg::CfgDataW-1:0]    cfg_data_i
);

  efr_pkg::efr_cfg_t    cfg_q, cfg_d;
  efr_pkg::efr_state_t  state_q, state_d;
  efr_pkg::efr_result_t step_res;
  efr_pkg::efr_result_t res_q;

  logic       in_valid_q;
  logic       in_mode_q;
  logic [7:0] in_byte_q;
  logic       advance;

  // Advance the held item once the result slot is free or being drained.
  assign advance     = in_valid_q && (!res_q.valid || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_mode_q <= mode_i;
      in_byte_q <= rx_byte_i;
    end
  end

  // Configuration registers: decode the index, drop writes beyond the list.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        efr_pkg::CfgStartByte:  cfg_d.start_byte      = cfg_data_i[7:0];
        efr_pkg::CfgEndByte:    cfg_d.end_byte        = cfg_data_i[7:0];
        efr_pkg::CfgEscapeByte: cfg_d.escape_byte     = cfg_data_i[7:0];
        efr_pkg::CfgInitTmo:    cfg_d.initial_timeout = cfg_data_i[efr_pkg::TmoW-1:0];
        efr_pkg::CfgByteCredit: cfg_d.byte_credit     = cfg_data_i[7:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte      <= efr_pkg::RstStartByte;
      cfg_q.end_byte        <= efr_pkg::RstEndByte;
      cfg_q.escape_byte     <= efr_pkg::RstEscapeByte;
      cfg_q.initial_timeout <= efr_pkg::RstInitTmo;
      cfg_q.byte_credit     <= efr_pkg::RstByteCredit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  efr_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .mode_i    (in_mode_q),
    .rx_byte_i (in_byte_q),
    .state_o   (state_d),
    .res_o     (step_res)
  );

  // Receiver state: update once per advanced item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= efr_pkg::PhIdle;
      state_q.escape_pending <= 1'b0;
      state_q.stored_count   <= '0;
      state_q.command_count  <= '0;
      state_q.timeout_left   <= '0;
      state_q.delay_low      <= '0;
      state_q.delay_value    <= efr_pkg::RstDelay;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: load on advance, clear the flag once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (advance) begin
      res_q.valid <= step_res.valid;
      if (step_res.valid) begin
        res_q.event_res    <= step_res.event_res;
        res_q.data_byte    <= step_res.data_byte;
        res_q.byte_index   <= step_res.byte_index;
        res_q.frame_length <= step_res.frame_length;
        res_q.reboot_delay <= step_res.reboot_delay;
      end
    end else if (out_ready_i) begin
      res_q.valid <= 1'b0;
    end
  end

  assign out_valid_o    = res_q.valid;
  assign event_res_o    = res_q.event_res;
  assign data_byte_o    = res_q.data_byte;
  assign byte_index_o   = res_q.byte_index;
  assign frame_length_o = res_q.frame_length;
  assign reboot_delay_o = res_q.reboot_delay;

  // Checks
  `ASSERT_NEVER(a_count_bound, state_q.stored_count > efr_pkg::CountW'(efr_pkg::BufDepth), "stored count beyond buffer depth")
  `ASSERT_NEVER(a_escape_in_frame, state_q.escape_pending && state_q.phase != efr_pkg::PhFrame, "escape pending outside a frame")
  `ASSERT_NEVER(a_cmd_bound, state_q.command_count > efr_pkg::CmdPosLast, "command position past last byte")
  `ASSERT_CLK(a_result_lands, advance && step_res.valid |=> res_q.valid, "result lost on advance")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of escaped_frame_receiver_unit: framing, escapes, reboot commands.
// Depends on efr_pkg and the RTL of the unit; a scoreboard class predicts every result.

module tb_top;

  localparam int CycleLimit = 400000;
  localparam int IdlePct    = 13;

  // Track the receiver: predict results from accepted transactions, check delivered ones.
  class frame_scoreboard;
    efr_pkg::efr_cfg_t                   regs;
    logic [1:0]                          phase;
    logic                                esc_pending;
    logic [efr_pkg::CountW-1:0]          stored;
    logic [3:0]                          cmd_pos;
    logic [efr_pkg::TmoW-1:0]            tmo_left;
    logic [7:0]                          delay_lo;
    logic [efr_pkg::DelayW-1:0]          delay_val;
    efr_pkg::efr_result_t                pending_events[$];
    int                                  failures;

    function new();
      regs.start_byte      = efr_pkg::RstStartByte;
      regs.end_byte        = efr_pkg::RstEndByte;
      regs.escape_byte     = efr_pkg::RstEscapeByte;
      regs.initial_timeout = efr_pkg::RstInitTmo;
      regs.byte_credit     = efr_pkg::RstByteCredit;
      phase       = efr_pkg::PhIdle;
      esc_pending = 1'b0;
      stored      = '0;
      cmd_pos     = '0;
      tmo_left    = '0;
      delay_lo    = '0;
      delay_val   = efr_pkg::RstDelay;
      failures    = 0;
    endfunction

    function void load_reg(logic [efr_pkg::CfgIdxW-1:0] idx,
                           logic [efr_pkg::CfgDataW-1:0] data);
      case (idx)
        efr_pkg::CfgStartByte:  regs.start_byte      = data[7:0];
        efr_pkg::CfgEndByte:    regs.end_byte        = data[7:0];
        efr_pkg::CfgEscapeByte: regs.escape_byte     = data[7:0];
        efr_pkg::CfgInitTmo:    regs.initial_timeout = data[efr_pkg::TmoW-1:0];
        efr_pkg::CfgByteCredit: regs.byte_credit     = data[7:0];
        default: ;
      endcase
    endfunction

    function efr_pkg::efr_result_t make_event(logic [efr_pkg::EvW-1:0] ev, logic [7:0] data,
                                              logic [efr_pkg::IdxW-1:0] idx,
                                              logic [efr_pkg::LenW-1:0] len,
                                              logic [efr_pkg::DelayW-1:0] dly);
      efr_pkg::efr_result_t r;
      r.valid        = 1'b1;
      r.event_res    = ev;
      r.data_byte    = data;
      r.byte_index   = idx;
      r.frame_length = len;
      r.reboot_delay = dly;
      return r;
    endfunction

    function efr_pkg::efr_result_t abort_frame();
      phase       = efr_pkg::PhIdle;
      cmd_pos     = '0;
      esc_pending = 1'b0;
      return make_event(efr_pkg::EvAbort, '0, '0, '0, '0);
    endfunction

    // Advance the receiver by one byte or tick; return 1 when it yields a result.
    function bit decode_item(logic tick, logic [7:0] b, output efr_pkg::efr_result_t r);
      logic                       busy;
      logic [16:0]                sum;
      logic [7:0]                 v;
      logic [efr_pkg::CountW-1:0] idx;
      logic [3:0]                 pos;
      r = '0;
      busy = (phase == efr_pkg::PhFrame) || (phase == efr_pkg::PhCmd);
      if (tick) begin
        if (!busy) return 1'b0;
        if (tmo_left != 0) tmo_left = tmo_left - 1'b1;
        if (tmo_left == 0) begin
          r = abort_frame();
          return 1'b1;
        end
        return 1'b0;
      end
      if (!busy) begin
        phase = efr_pkg::PhIdle;
        // A start byte equal to the command sync opens a normal frame.
        if (b == regs.start_byte) begin
          esc_pending = 1'b0;
          stored      = efr_pkg::CountW'(1);
          tmo_left    = regs.initial_timeout;
          if (tmo_left == 0) begin
            r = abort_frame();
            return 1'b1;
          end
          phase = efr_pkg::PhFrame;
          r = make_event(efr_pkg::EvStored, b, '0, '0, '0);
          return 1'b1;
        end
        if (b == efr_pkg::CmdSync) begin
          esc_pending = 1'b0;
          cmd_pos     = 4'd1;
          tmo_left    = regs.initial_timeout;
          if (tmo_left == 0) begin
            r = abort_frame();
            return 1'b1;
          end
          phase = efr_pkg::PhCmd;
        end
        return 1'b0;
      end
      if (phase == efr_pkg::PhFrame) begin
        if (stored >= efr_pkg::CountW'(efr_pkg::BufDepth)) begin
          r = make_event(efr_pkg::EvOverflow, '0, '0, '0, '0);
          return 1'b1;
        end
        sum = tmo_left + regs.byte_credit;
        tmo_left = sum[16] ? '1 : sum[efr_pkg::TmoW-1:0];
        if (!esc_pending && b == regs.escape_byte) begin
          esc_pending = 1'b1;
          if (tmo_left == 0) begin
            r = abort_frame();
            return 1'b1;
          end
          return 1'b0;
        end
        v = esc_pending ? 8'(regs.escape_byte + b) : b;
        idx = stored;
        stored = stored + 1'b1;
        if (!esc_pending && b == regs.end_byte) begin
          phase = efr_pkg::PhIdle;
          r = make_event(efr_pkg::EvDone, v, idx[efr_pkg::IdxW-1:0], stored, '0);
          return 1'b1;
        end
        esc_pending = 1'b0;
        if (tmo_left == 0) begin
          r = abort_frame();
          return 1'b1;
        end
        r = make_event(efr_pkg::EvStored, v, idx[efr_pkg::IdxW-1:0], '0, '0);
        return 1'b1;
      end
      // Reboot command byte
      pos = cmd_pos;
      if ((pos == 4'd1 && b != efr_pkg::CmdByte1) || (pos == 4'd2 && b != efr_pkg::CmdByte2) ||
          (pos == 4'd3 && b != efr_pkg::CmdByte3) || (pos == 4'd5 && b != efr_pkg::CmdByte5))
      begin
        tmo_left = '0;
        r = abort_frame();
        return 1'b1;
      end
      if (pos == efr_pkg::CmdPosDelayLo) delay_lo = b;
      if (pos == efr_pkg::CmdPosDelayHi) delay_val = {b, delay_lo};
      cmd_pos = pos + 1'b1;
      if (pos >= efr_pkg::CmdPosLast) begin
        cmd_pos = '0;
        phase   = efr_pkg::PhIdle;
        r = make_event(efr_pkg::EvReboot, '0, '0, '0, delay_val);
        return 1'b1;
      end
      if (tmo_left == 0) begin
        r = abort_frame();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Note an accepted input; return 1 unless the receiver simply dropped it.
    function bit note_input(logic tick, logic [7:0] b);
      efr_pkg::efr_result_t r;
      logic                 was_busy;
      bit                   hit;
      was_busy = (phase != efr_pkg::PhIdle);
      hit = decode_item(tick, b, r);
      if (hit) pending_events.push_back(r);
      return hit || was_busy || (phase != efr_pkg::PhIdle);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(efr_pkg::efr_result_t got);
      efr_pkg::efr_result_t want;
      if (pending_events.size() == 0) begin
        note_failure($sformatf("unexpected result ev=%0d data=%02h idx=%0d len=%0d dly=%04h",
                               got.event_res, got.data_byte, got.byte_index,
                               got.frame_length, got.reboot_delay));
        return;
      end
      want = pending_events.pop_front();
      if (got.event_res != want.event_res || got.data_byte != want.data_byte ||
          got.byte_index != want.byte_index || got.frame_length != want.frame_length ||
          got.reboot_delay != want.reboot_delay)
        note_failure($sformatf({"mismatch: expected ev=%0d data=%02h idx=%0d len=%0d dly=%04h,",
                                " got ev=%0d data=%02h idx=%0d len=%0d dly=%04h"},
                               want.event_res, want.data_byte, want.byte_index,
                               want.frame_length, want.reboot_delay,
                               got.event_res, got.data_byte, got.byte_index,
                               got.frame_length, got.reboot_delay));
    endfunction

    function int outstanding();
      return pending_events.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_n;

  logic                         in_valid;
  logic                         in_ready;
  logic                         mode;
  logic [7:0]                   rx_byte;
  logic                         out_valid;
  logic                         out_ready;
  logic [efr_pkg::EvW-1:0]      event_res;
  logic [7:0]                   data_byte;
  logic [efr_pkg::IdxW-1:0]     byte_index;
  logic [efr_pkg::LenW-1:0]     frame_length;
  logic [efr_pkg::DelayW-1:0]   reboot_delay;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [efr_pkg::CfgIdxW-1:0]  cfg_index;
  logic [efr_pkg::CfgDataW-1:0] cfg_data;

  frame_scoreboard sb = new();

  bit idle_on  = 1'b1;   // random idling on both channels
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off
  int live_items = 0;    // transactions that the receiver acted upon
  int cycles = 0;

  escaped_frame_receiver_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .event_res_o    (event_res),
    .data_byte_o    (data_byte),
    .byte_index_o   (byte_index),
    .frame_length_o (frame_length),
    .reboot_delay_o (reboot_delay),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check each delivered transaction, then pick the next ready value.
  // Outputs are sampled right after the edge, i.e. the values the edge saw.
  initial begin : result_sink
    int hold_left;
    efr_pkg::efr_result_t got;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_n && out_valid && out_ready) begin
        got.valid        = 1'b1;
        got.event_res    = event_res;
        got.data_byte    = data_byte;
        got.byte_index   = byte_index;
        got.frame_length = frame_length;
        got.reboot_delay = reboot_delay;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (idle_on) begin
        out_ready <= ($urandom_range(99) >= IdlePct);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one byte or tick; hold it until the input handshake completes.
  task automatic send_item(input logic tick, input logic [7:0] b);
    if (idle_on && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    mode     <= tick;
    rx_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    if (sb.note_input(tick, b)) live_items++;
  endtask

  // Stop the sender and wait until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    // Let items without a result clear the pipeline too.
    repeat (8) @(posedge clk_i);
  endtask

  // Write all five registers back to back; keep valid high across the burst.
  task automatic apply_setting(input logic [7:0] sb_start, input logic [7:0] sb_end,
                               input logic [7:0] sb_esc,
                               input logic [efr_pkg::TmoW-1:0] tmo,
                               input logic [7:0] credit);
    logic [efr_pkg::CfgIdxW-1:0]  idx [5];
    logic [efr_pkg::CfgDataW-1:0] val [5];
    idx = '{efr_pkg::CfgStartByte, efr_pkg::CfgEndByte, efr_pkg::CfgEscapeByte,
            efr_pkg::CfgInitTmo, efr_pkg::CfgByteCredit};
    // Fill unused upper bits at random; the byte registers drop them.
    val = '{{8'($urandom), sb_start}, {8'($urandom), sb_end}, {8'($urandom), sb_esc},
            tmo, {8'($urandom), credit}};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk_i); while (!cfg_ready);
      sb.load_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Frame payload byte, biased toward the codes that steer the decoder.
  function automatic logic [7:0] frame_content();
    int r;
    r = $urandom_range(99);
    if (r < 12) return sb.regs.escape_byte;
    if (r < 16) return sb.regs.end_byte;
    if (r < 20) return sb.regs.start_byte;
    if (r < 24) return efr_pkg::CmdSync;
    return 8'($urandom);
  endfunction

  task automatic send_frame();
    int n;
    send_item(1'b0, sb.regs.start_byte);
    n = $urandom_range(12);
    repeat (n) begin
      if ($urandom_range(9) == 0) send_item(1'b1, 8'($urandom));
      else send_item(1'b0, frame_content());
    end
    // Leave some frames open so ticks or later bytes must deal with them.
    if ($urandom_range(99) < 85) send_item(1'b0, sb.regs.end_byte);
  endtask

  task automatic send_command();
    logic [7:0] cmd [11];
    int r;
    int last;
    cmd = '{efr_pkg::CmdSync, efr_pkg::CmdByte1, efr_pkg::CmdByte2, efr_pkg::CmdByte3,
            8'($urandom), efr_pkg::CmdByte5, 8'($urandom), 8'($urandom), 8'($urandom),
            8'($urandom), 8'($urandom)};
    r = $urandom_range(99);
    last = 10;
    // Corrupt one checked position, or cut the command short.
    if (r < 20) begin
      case ($urandom_range(3))
        0: cmd[1] = cmd[1] ^ 8'($urandom_range(255, 1));
        1: cmd[2] = cmd[2] ^ 8'($urandom_range(255, 1));
        2: cmd[3] = cmd[3] ^ 8'($urandom_range(255, 1));
        default: cmd[5] = cmd[5] ^ 8'($urandom_range(255, 1));
      endcase
    end else if (r < 30) begin
      last = $urandom_range(9, 1);
    end
    for (int i = 0; i <= last; i++) begin
      if ($urandom_range(19) == 0) send_item(1'b1, 8'($urandom));
      send_item(1'b0, cmd[i]);
    end
  endtask

  task automatic run_random(input int count);
    int goal;
    int r;
    goal = live_items + count;
    while (live_items < goal) begin
      r = $urandom_range(99);
      if (r < 45) send_frame();
      else if (r < 70) send_command();
      else if (r < 82) repeat ($urandom_range(60, 1)) send_item(1'b1, 8'($urandom));
      else repeat ($urandom_range(4, 1)) send_item(1'($urandom_range(1)), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [8:0] directed [$];
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    mode      <= 1'b0;
    rx_byte   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part at reset settings; bit 8 marks a tick.
    directed = '{9'h000, 9'h0FF, 9'h100,                      // dropped in idle
                 9'h0E1, 9'h000, 9'h0FF, 9'h0E0, 9'h0E2,      // escaped end stays data
                 9'h0E0, 9'h0E0, 9'h0E2,                      // escaped escape, then done
                 9'h055, 9'h0AA, 9'h001, 9'h0E7, 9'h000, 9'h002,
                 9'h000, 9'h034, 9'h012, 9'h000, 9'h000,      // reboot with delay 0x1234
                 9'h055, 9'h0AB};                             // command mismatch
    foreach (directed[i]) send_item(directed[i][8], directed[i][7:0]);
    wait_drained();

    // Zero initial timeout: the opening byte aborts on the spot.
    apply_setting(efr_pkg::RstStartByte, efr_pkg::RstEndByte, efr_pkg::RstEscapeByte,
                  16'd0, efr_pkg::RstByteCredit);
    send_item(1'b0, efr_pkg::RstStartByte);
    send_item(1'b0, efr_pkg::CmdSync);
    wait_drained();

    // Reset settings, with one long receiver hold-off while the sender keeps going.
    apply_setting(efr_pkg::RstStartByte, efr_pkg::RstEndByte, efr_pkg::RstEscapeByte,
                  efr_pkg::RstInitTmo, efr_pkg::RstByteCredit);
    run_random(65);
    hold_req = 1'b1;
    run_random(65);
    // Pause the sender until everything is out, then resume.
    wait_drained();
    run_random(25);
    wait_drained();

    // High extremes; start byte shadows the command sync. Run without idling.
    idle_on = 1'b0;
    apply_setting(efr_pkg::CmdSync, 8'h00, 8'hFF, 16'hFFFF, 8'hFF);
    run_random(80);
    wait_drained();
    idle_on = 1'b1;

    // Low extremes: a single tick ends any frame, no byte credit.
    apply_setting(8'h00, 8'hFF, 8'h00, 16'd1, 8'd0);
    run_random(80);
    wait_drained();

    apply_setting(8'hFF, 8'($urandom), 8'($urandom), 16'($urandom_range(200, 1)),
                  8'($urandom_range(8)));
    run_random(60);
    wait_drained();

    apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(200, 1)),
                  8'($urandom_range(8)));
    run_random(60);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (sb.outstanding() != 0)
      sb.note_failure($sformatf("%0d expected results never arrived", sb.outstanding()));
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== escaped_frame_receiver_unit.f =====
+incdir+hdl
hdl/efr_pkg.sv
hdl/efr_step.sv
hdl/escaped_frame_receiver_unit.sv
tb/sv/tb_top.sv
